[hw/rtl/text_mode_terminal_writer_core_defines.svh]
// Assertion macros shared by the terminal writer modules.
`ifndef TEXT_MODE_TERMINAL_WRITER_CORE_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define TMTW_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);
// Checks that a condition never occurs outside reset.
`define TMTW_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);
`else
`define TMTW_ASSERT(name, clk, rstn, prop, msg)
`define TMTW_ASSERT_NEVER(name, clk, rstn, cond, msg)
`endif

`endif

[hw/rtl/tmtw_pkg.sv]
// Types and constants of the text mode terminal writer.
package tmtw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;
  localparam int Q_DEPTH     = 2;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [15:0] INIT_CELL  = 16'h0720;
  localparam logic [3:0]  FG_RESET   = 4'd7;
  localparam logic [3:0]  BG_RESET   = 4'd0;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_READ_OOB
  } op_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] character;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tmtw_in_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
  } tmtw_out_t;

  typedef struct packed {
    op_e        kind;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } tmtw_op_t;

endpackage

[hw/rtl/text_mode_terminal_writer_core.sv]
// Top level of the text mode terminal writer: front, queue and back.
//
// Commands arrive on the input channel (in_valid_i / in_ready_o / in_data_i) and
// every command gives exactly one result transfer on the output channel
// (out_valid_o / out_ready_i / out_data_o) carrying the cursor after the command.
// The front classifies each transfer and drops it into a two-entry queue; the back
// executes one operation at a time against a single-port cell store.
// A plain character passes through the queue and is executed straight into the
// output register. A read also passes through the registered store read.
// A newline on the last row rotates the row base and blanks the new bottom row,
// one cell per cycle, and a clear writes every cell in the same way; the store's
// single write port sets this pace. After reset the back fills all ROWS * COLUMNS
// cells (2000 by default) of the store with spaces in attribute 0x07; input
// transfers are queued but not executed until that pass is done. Configuration
// writes are taken at any time.
// When the receiver stalls, the finished result holds in the output register and
// the back waits; the queue keeps taking input until it is full.
module text_mode_terminal_writer_core #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmtw_pkg::tmtw_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmtw_pkg::tmtw_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [3:0]          cfg_wdata_i
);
  import tmtw_pkg::*;

  // Operations travel from the classifier to the executor through the queue.
  tmtw_op_t push_op, head_op;
  logic     q_push, q_full, q_valid, q_pop;

  tmtw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_op_o    (push_op)
  );

  tmtw_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .push_op_i(push_op),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .valid_o  (q_valid),
    .head_op_o(head_op)
  );

  // The back owns the cursor, the colour registers and the cell store.
  tmtw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (head_op),
    .op_pop_o   (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

endmodule

[hw/rtl/tmtw_fifo.sv]
// Short queue of classified operations between front and back.
`include "text_mode_terminal_writer_core_defines.svh"
module tmtw_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tmtw_pkg::tmtw_op_t push_op_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output tmtw_pkg::tmtw_op_t head_op_o
);
  import tmtw_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);

  tmtw_op_t        slot_q [Q_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;

  assign full_o    = (cnt_q == NW'(Q_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign head_op_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_op_i;
    end
  end

  `TMTW_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "queue push while full")
  `TMTW_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o, "queue pop while empty")
  `TMTW_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= NW'(Q_DEPTH), "queue count off range")

endmodule

[hw/rtl/tmtw_front.sv]
// Input side: takes command transfers and classifies them into operations.
module tmtw_front #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tmtw_pkg::tmtw_in_t in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output tmtw_pkg::tmtw_op_t q_op_o
);
  import tmtw_pkg::*;

  logic in_bounds;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign in_bounds  = (32'(in_data_i.read_row) < ROWS) && (32'(in_data_i.read_col) < COLUMNS);

  always_comb begin
    q_op_o.ch  = in_data_i.character;
    q_op_o.row = in_data_i.read_row;
    q_op_o.col = in_data_i.read_col;
    unique case (in_data_i.command)
      CMD_PUT:   q_op_o.kind = (in_data_i.character == CH_NEWLINE) ? OP_NEWLINE : OP_PUT;
      CMD_CLEAR: q_op_o.kind = OP_CLEAR;
      CMD_READ:  q_op_o.kind = in_bounds ? OP_READ : OP_READ_OOB;
      default:   q_op_o.kind = OP_NOP;
    endcase
  end

endmodule

[hw/rtl/tmtw_back.sv]
// Execution side: cursor, cell store, fill sweeps and the result register.
`include "text_mode_terminal_writer_core_defines.svh"
module tmtw_back #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  input  tmtw_pkg::tmtw_op_t  op_i,
  output logic                op_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmtw_pkg::tmtw_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [3:0]          cfg_wdata_i
);
  import tmtw_pkg::*;

  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLUMNS + 1);
  localparam int CIW    = $clog2(COLUMNS);
  localparam int NCELLS = ROWS * COLUMNS;
  localparam int AW     = $clog2(NCELLS);
  localparam logic [RW:0] ROWS_W = (RW + 1)'(ROWS);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [1:0]    st_q, st_d;
  logic [RW-1:0] cur_row_q, cur_row_d, base_q, base_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [AW-1:0] swp_addr_q, swp_addr_d, swp_left_q, swp_left_d;
  logic [15:0]   fill_q, fill_d, pend_cell_q, pend_cell_d;
  logic          pend_q, pend_d;
  logic [3:0]    fg_q, bg_q;
  logic          out_valid_q, out_valid_d;
  tmtw_out_t     out_data_q, out_data_d;
  logic [15:0]   rd_q;
  logic [15:0]   mem [NCELLS];

  logic [7:0]     attr;
  logic [15:0]    blank, put_cell;
  logic           can_go, last_row, wrap;
  logic [RW-1:0]  sel_row, phys_row;
  logic [CIW-1:0] sel_col;
  logic [RW:0]    row_sum;
  logic [AW-1:0]  acc_addr, scroll_addr, mem_waddr;
  logic [15:0]    mem_wdata;
  logic           mem_we, rd_en, emit;
  logic [7:0]     emit_char, emit_attr;

  assign attr     = {bg_q, fg_q};
  assign blank    = {attr, CH_SPACE};
  assign put_cell = {attr, op_i.ch};
  assign can_go   = (st_q == ST_IDLE) && op_valid_i && (!out_valid_q || out_ready_i);
  assign last_row = (cur_row_q == RW'(ROWS - 1));
  assign wrap     = (cur_col_q == CW'(COLUMNS));

  // Logical rows sit rotated by base_q in the store; a scroll moves base_q, not rows.
  always_comb begin
    if (op_i.kind == OP_READ) begin
      sel_row = RW'(op_i.row);
      sel_col = CIW'(op_i.col);
    end else if (wrap) begin
      sel_row = cur_row_q + 1'b1;
      sel_col = '0;
    end else begin
      sel_row = cur_row_q;
      sel_col = CIW'(cur_col_q);
    end
    row_sum  = {1'b0, sel_row} + {1'b0, base_q};
    phys_row = (row_sum >= ROWS_W) ? RW'(row_sum - ROWS_W) : RW'(row_sum);
  end

  assign acc_addr    = AW'(phys_row) * AW'(COLUMNS) + AW'(sel_col);
  assign scroll_addr = AW'(base_q) * AW'(COLUMNS);

  always_comb begin
    st_d        = st_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    base_d      = base_q;
    swp_addr_d  = swp_addr_q;
    swp_left_d  = swp_left_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    pend_cell_d = pend_cell_q;
    mem_we      = 1'b0;
    mem_waddr   = acc_addr;
    mem_wdata   = put_cell;
    rd_en       = 1'b0;
    op_pop_o    = 1'b0;
    emit        = 1'b0;
    emit_char   = '0;
    emit_attr   = '0;
    unique case (st_q)
      ST_INIT: begin
        mem_we     = 1'b1;
        mem_waddr  = swp_addr_q;
        mem_wdata  = INIT_CELL;
        swp_addr_d = swp_addr_q + 1'b1;
        swp_left_d = swp_left_q - 1'b1;
        if (swp_left_q == '0) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (can_go) begin
          op_pop_o = 1'b1;
          unique case (op_i.kind) inside
            OP_PUT, OP_NEWLINE: begin
              if (op_i.kind == OP_PUT && !wrap) begin
                mem_we    = 1'b1;
                cur_col_d = cur_col_q + 1'b1;
                emit      = 1'b1;
              end else if (!last_row) begin
                mem_we    = (op_i.kind == OP_PUT);
                cur_row_d = cur_row_q + 1'b1;
                cur_col_d = (op_i.kind == OP_PUT) ? CW'(1) : '0;
                emit      = 1'b1;
              end else begin
                st_d        = ST_SWEEP;
                swp_addr_d  = scroll_addr;
                swp_left_d  = AW'(COLUMNS - 1);
                fill_d      = blank;
                pend_d      = (op_i.kind == OP_PUT);
                pend_cell_d = put_cell;
                cur_col_d   = (op_i.kind == OP_PUT) ? CW'(1) : '0;
                base_d      = (base_q == RW'(ROWS - 1)) ? '0 : base_q + 1'b1;
              end
            end
            OP_CLEAR: begin
              st_d       = ST_SWEEP;
              swp_addr_d = '0;
              swp_left_d = AW'(NCELLS - 1);
              fill_d     = blank;
              pend_d     = 1'b0;
            end
            OP_READ: begin
              rd_en = 1'b1;
              st_d  = ST_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        mem_we     = 1'b1;
        mem_waddr  = swp_addr_q;
        mem_wdata  = pend_q ? pend_cell_q : fill_q;
        pend_d     = 1'b0;
        swp_addr_d = swp_addr_q + 1'b1;
        swp_left_d = swp_left_q - 1'b1;
        if (swp_left_q == '0) begin
          st_d = ST_IDLE;
          emit = 1'b1;
        end
      end
      ST_READ: begin
        emit      = 1'b1;
        emit_char = rd_q[7:0];
        emit_attr = rd_q[15:8];
        st_d      = ST_IDLE;
      end
      default: begin
        st_d = ST_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d           = 1'b1;
      out_data_d.cell_char  = emit_char;
      out_data_d.cell_attr  = emit_attr;
      out_data_d.cursor_row = 5'(cur_row_d);
      out_data_d.cursor_col = 7'(cur_col_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_INIT;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      base_q      <= '0;
      swp_addr_q  <= '0;
      swp_left_q  <= AW'(NCELLS - 1);
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fg_q        <= FG_RESET;
      bg_q        <= BG_RESET;
    end else begin
      st_q        <= st_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      base_q      <= base_d;
      swp_addr_q  <= swp_addr_d;
      swp_left_q  <= swp_left_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FG:  fg_q <= cfg_wdata_i;
          REG_BG:  bg_q <= cfg_wdata_i;
          default: fg_q <= fg_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q      <= fill_d;
    pend_cell_q <= pend_cell_d;
    out_data_q  <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem[acc_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TMTW_ASSERT(a_row_bound, clk_i, rst_ni, 32'(cur_row_q) < ROWS, "cursor row off screen")
  `TMTW_ASSERT(a_col_bound, clk_i, rst_ni, 32'(cur_col_q) <= COLUMNS, "cursor column off range")
  `TMTW_ASSERT(a_base_bound, clk_i, rst_ni, 32'(base_q) < ROWS, "scroll base off range")

endmodule
